/* src/ets_pkg.sv */
package ets_pkg;

   // widths of the time split
   localparam int SEC_W     = 38;           // seconds above the low clamp bound
   localparam int DAY_W     = 22;           // day count above the low clamp bound
   localparam int TOD_W     = 17;           // second of the day
   localparam int DAY_LOW_W = 7;            // 86400 = 675 * 2^7
   localparam int DIGITS    = 14;
   localparam int CHAR_W    = 7;
   localparam int LINE_DEPTH = 2;

   localparam logic signed [39:0] SEC_LOW  = -40'sd17987443200;
   localparam logic signed [39:0] SEC_HIGH = 40'sd253402300799;
   localparam logic [SEC_W-1:0]   SEC_SPAN = 38'd271389743999;
   localparam logic [9:0]         DAY_ODD  = 10'd675;
   // days from 0000-03-01 to 1400-01-01
   localparam logic [DAY_W-1:0]   DAY_BIAS = 22'd511280;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_T    = 7'h54;
   localparam logic [CHAR_W-1:0] CHAR_Z    = 7'h5A;
   localparam logic [3:0]        POS_T     = 4'd8;
   localparam logic [3:0]        POS_Z     = 4'd15;

   localparam logic [17:0] ERA_DAYS = 18'd146097;

   // floor(x / d) == (x * ceil(2^s / d)) >> s for x < 2^(s - ceil(log2 d))
   localparam int DAY_SHIFT = 41;
   localparam logic [31:0] DAY_RECIP = 32'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
   localparam int ERA_SHIFT = 40;
   localparam logic [22:0] ERA_RECIP = 23'(((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097);
   localparam int D1460_SHIFT = 29;
   localparam logic [18:0] D1460_RECIP = 19'(((64'd1 << D1460_SHIFT) + 64'd1459) / 64'd1460);
   localparam int D365_SHIFT = 27;
   localparam logic [18:0] D365_RECIP = 19'(((64'd1 << D365_SHIFT) + 64'd364) / 64'd365);
   localparam int D153_SHIFT = 19;
   localparam logic [11:0] D153_RECIP = 12'(((64'd1 << D153_SHIFT) + 64'd152) / 64'd153);
   localparam int D100_SHIFT = 21;
   localparam logic [14:0] D100_RECIP = 15'(((64'd1 << D100_SHIFT) + 64'd99) / 64'd100);
   localparam int D3600_SHIFT = 29;
   localparam logic [17:0] D3600_RECIP = 18'(((64'd1 << D3600_SHIFT) + 64'd3599) / 64'd3600);
   localparam int D60_SHIFT = 18;
   localparam logic [12:0] D60_RECIP = 13'(((64'd1 << D60_SHIFT) + 64'd59) / 64'd60);
   localparam int D10_SHIFT = 11;
   localparam logic [7:0] D10_RECIP = 8'(((64'd1 << D10_SHIFT) + 64'd9) / 64'd10);

   typedef logic [3:0] digit_type;
   typedef digit_type [DIGITS-1:0] line_type;

   // first day of each month in a March-based year
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] r;
      unique case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

/* src/epoch_seconds_to_iso_text_top.sv */
// Converts signed seconds since 1970-01-01T00:00:00Z into the text
// YYYYMMDDTHHMMSSZ, one ASCII character per result item, with rsp_last_char
// set on the closing Z. Counts outside the years 1400..9999 saturate to the
// nearest bound. Each item yields sixteen results; the result port moves one
// character per cycle while rsp_pop is held and a line is waiting. Behind the
// input queue a reciprocal multiply, registered first in dq_ff and then in
// quo_ff and rem_ff, splits the count into day and second of day, and an
// 11-stage calendar and digit pipeline follows. Up to two finished lines wait
// behind the character being shown.
module epoch_seconds_to_iso_text_top #(
   parameter int REQ_QUEUE_DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  logic signed [38:0]           req_epoch_seconds,
   output logic                         req_full,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [ets_pkg::CHAR_W-1:0]   rsp_text_char,
   output logic                         rsp_last_char
);
   import ets_pkg::*;

   logic [SEC_W-1:0] span, q_data;
   logic             q_empty, q_pop;
   logic             line_push, line_pop, line_empty;
   line_type         line_in, line_out;

   ets_front u_front (
      .epoch_seconds (req_epoch_seconds),
      .span          (span)
   );

   ets_fifo #(
      .WIDTH (SEC_W),
      .DEPTH (REQ_QUEUE_DEPTH)
   ) u_req_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (span),
      .full      (req_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   ets_cal u_cal (
      .clock     (clock),
      .reset     (reset),
      .src_empty (q_empty),
      .src_data  (q_data),
      .src_pop   (q_pop),
      .line_pop  (line_pop),
      .line_push (line_push),
      .line_data (line_in)
   );

   ets_fifo #(
      .WIDTH ($bits(line_type)),
      .DEPTH (LINE_DEPTH)
   ) u_line_q (
      .clock     (clock),
      .reset     (reset),
      .push      (line_push),
      .push_data (line_in),
      .full      (),
      .pop       (line_pop),
      .empty     (line_empty),
      .pop_data  (line_out)
   );

   ets_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .line_empty    (line_empty),
      .line_data     (line_out),
      .line_pop      (line_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

/* src/ets_fifo.sv */
module ets_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* src/ets_front.sv */
module ets_front (
   input  logic signed [38:0]          epoch_seconds,
   output logic [ets_pkg::SEC_W-1:0]   span
);
   import ets_pkg::*;

   logic signed [39:0] wide;
   logic signed [39:0] shifted;

   assign wide    = 40'(epoch_seconds);
   assign shifted = wide - SEC_LOW;

   // saturate to years 1400..9999, then rebase so the value is never negative
   always_comb begin
      priority if (wide < SEC_LOW) begin
         span = '0;
      end else if (wide > SEC_HIGH) begin
         span = SEC_SPAN;
      end else begin
         span = shifted[SEC_W-1:0];
      end
   end

endmodule

/* src/ets_cal.sv */
module ets_cal (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         src_empty,
   input  logic [ets_pkg::SEC_W-1:0]    src_data,
   output logic                         src_pop,
   input  logic                         line_pop,
   output logic                         line_push,
   output ets_pkg::line_type            line_data
);
   import ets_pkg::*;

   localparam int CREDIT_W = $clog2(LINE_DEPTH + 1);
   localparam int STAGES   = 11;
   localparam int HI_W     = SEC_W - DAY_LOW_W;
   localparam int PROD_W   = HI_W + 32;

   // ---------------- day split: 86400 = 675 * 2^7 ----------------
   logic                  start;
   logic [CREDIT_W-1:0]   credit_ff, credit_in;
   logic [HI_W-1:0]       sec_hi;
   logic [PROD_W-1:0]     day_prod;
   logic [HI_W-1:0]       day_rem;
   logic                  split_ff, done_ff;
   logic [DAY_W-1:0]      dq_ff, quo_ff;
   logic [HI_W-1:0]       dx_ff;
   logic [DAY_LOW_W-1:0]  dlow_ff;
   logic [TOD_W-1:0]      rem_ff;

   assign start     = !src_empty && (credit_ff < CREDIT_W'(LINE_DEPTH));
   assign src_pop   = start;
   assign sec_hi    = src_data[SEC_W-1:DAY_LOW_W];
   assign day_prod  = PROD_W'(sec_hi) * PROD_W'(DAY_RECIP);
   // remainder of the odd factor is below 675, the low seven bits pass through
   assign day_rem   = dx_ff - HI_W'(dq_ff) * HI_W'(DAY_ODD);
   assign credit_in = credit_ff + CREDIT_W'(start) - CREDIT_W'(line_pop);

   // ---------------- calendar pipeline ----------------
   logic [STAGES-1:0] valid_ff, valid_in;

   // stage 1
   logic [DAY_W-1:0] z_day;
   logic [44:0]      era_prod;
   logic [34:0]      hh_prod;
   logic [DAY_W-1:0] z1_ff;
   logic [4:0]       era1_ff, era1_in;
   logic [TOD_W-1:0] tod1_ff;
   logic [4:0]       hh1_ff, hh1_in;

   assign z_day    = quo_ff + DAY_BIAS;
   assign era_prod = 45'(z_day) * 45'(ERA_RECIP);
   assign era1_in  = era_prod[ERA_SHIFT +: 5];
   assign hh_prod  = 35'(rem_ff) * 35'(D3600_RECIP);
   assign hh1_in   = hh_prod[D3600_SHIFT +: 5];

   // stage 2
   logic [DAY_W-1:0] doe_full;
   logic [TOD_W-1:0] remh_full;
   logic [17:0]      doe2_ff;
   logic [4:0]       era2_ff, hh2_ff;
   logic [11:0]      remh2_ff;

   assign doe_full  = z1_ff - DAY_W'(era1_ff) * DAY_W'(ERA_DAYS);
   assign remh_full = tod1_ff - TOD_W'(hh1_ff) * TOD_W'(3600);

   // stage 3
   logic [36:0] a_prod;
   logic [6:0]  a_val;
   logic [2:0]  cent;
   logic        era_end;
   logic [24:0] mm_prod;
   logic [17:0] t3_ff, t3_in, doe3_ff;
   logic [4:0]  era3_ff, hh3_ff;
   logic [5:0]  mm3_ff, mm3_in;
   logic [11:0] remh3_ff;

   assign a_prod  = 37'(doe2_ff) * 37'(D1460_RECIP);
   assign a_val   = a_prod[D1460_SHIFT +: 7];
   assign cent    = 3'(doe2_ff >= 18'd36524) + 3'(doe2_ff >= 18'd73048)
                  + 3'(doe2_ff >= 18'd109572) + 3'(doe2_ff >= 18'd146096);
   assign era_end = (doe2_ff == 18'd146096);
   assign t3_in   = doe2_ff - 18'(a_val) + 18'(cent) - 18'(era_end);
   assign mm_prod = 25'(remh2_ff) * 25'(D60_RECIP);
   assign mm3_in  = mm_prod[D60_SHIFT +: 6];

   // stage 4
   logic [36:0] yoe_prod;
   logic [11:0] ss_full;
   logic [8:0]  yoe4_ff, yoe4_in;
   logic [17:0] doe4_ff;
   logic [4:0]  era4_ff, hh4_ff;
   logic [5:0]  mm4_ff, ss4_ff;

   assign yoe_prod = 37'(t3_ff) * 37'(D365_RECIP);
   assign yoe4_in  = yoe_prod[D365_SHIFT +: 9];
   assign ss_full  = remh3_ff - 12'(mm3_ff) * 12'(60);

   // stage 5
   logic [1:0]  ycent;
   logic [17:0] yoe_days, doy_full;
   logic [8:0]  doy5_ff;
   logic [13:0] ybase5_ff, ybase5_in;
   logic [4:0]  hh5_ff;
   logic [5:0]  mm5_ff, ss5_ff;

   assign ycent    = 2'(yoe4_ff >= 9'd100) + 2'(yoe4_ff >= 9'd200) + 2'(yoe4_ff >= 9'd300);
   assign yoe_days = 18'(yoe4_ff) * 18'(365) + 18'(yoe4_ff >> 2) - 18'(ycent);
   assign doy_full = doe4_ff - yoe_days;
   assign ybase5_in = 14'(yoe4_ff) + 14'(era4_ff) * 14'(400);

   // stage 6
   logic [10:0] mp_arg;
   logic [22:0] mp_prod;
   logic [3:0]  mp6_ff, mp6_in;
   logic [8:0]  doy6_ff;
   logic [13:0] ybase6_ff;
   logic [4:0]  hh6_ff;
   logic [5:0]  mm6_ff, ss6_ff;

   assign mp_arg  = 11'(doy5_ff) * 11'(5) + 11'(2);
   assign mp_prod = 23'(mp_arg) * 23'(D153_RECIP);
   assign mp6_in  = mp_prod[D153_SHIFT +: 4];

   // stage 7
   logic [8:0]  day_full;
   logic        early;     // January and February belong to the next civil year
   logic [4:0]  day7_ff;
   logic [3:0]  month7_ff, month7_in;
   logic [13:0] year7_ff;
   logic [4:0]  hh7_ff;
   logic [5:0]  mm7_ff, ss7_ff;

   assign day_full  = doy6_ff - month_start(mp6_ff) + 9'd1;
   assign early     = (mp6_ff >= 4'd10);
   assign month7_in = early ? mp6_ff - 4'd9 : mp6_ff + 4'd3;

   // stage 8
   logic [28:0] yh_prod;
   logic [6:0]  yh8_ff, yh8_in;
   logic [13:0] year8_ff;
   logic [3:0]  month8_ff;
   logic [4:0]  day8_ff, hh8_ff;
   logic [5:0]  mm8_ff, ss8_ff;

   assign yh_prod = 29'(year7_ff) * 29'(D100_RECIP);
   assign yh8_in  = yh_prod[D100_SHIFT +: 7];

   // stage 9
   logic [13:0] yl_full;
   logic [6:0]  pair9_ff [7];

   assign yl_full = year8_ff - 14'(yh8_ff) * 14'(100);

   // stages 10 and 11: two digits per field
   logic [14:0] tens_prod [7];
   logic [6:0]  pair10_ff [7];
   logic [3:0]  tens10_ff [7];
   logic [6:0]  ones_full [7];
   line_type    line11_ff, line11_in;

   always_comb begin
      for (int i = 0; i < 7; i++) begin
         tens_prod[i] = 15'(pair9_ff[i]) * 15'(D10_RECIP);
         ones_full[i] = pair10_ff[i] - 7'(tens10_ff[i]) * 7'(10);
         line11_in[2*i]     = tens10_ff[i];
         line11_in[2*i + 1] = ones_full[i][3:0];
      end
   end

   assign valid_in  = {valid_ff[STAGES-2:0], done_ff};
   assign line_push = valid_ff[STAGES-1];
   assign line_data = line11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff  <= 1'b0;
         done_ff   <= 1'b0;
         credit_ff <= '0;
         valid_ff  <= '0;
      end else begin
         split_ff  <= start;
         done_ff   <= split_ff;
         credit_ff <= credit_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff   <= day_prod[DAY_SHIFT +: DAY_W];
      dx_ff   <= sec_hi;
      dlow_ff <= src_data[DAY_LOW_W-1:0];

      quo_ff <= dq_ff;
      rem_ff <= {day_rem[TOD_W-DAY_LOW_W-1:0], dlow_ff};

      z1_ff   <= z_day;
      era1_ff <= era1_in;
      tod1_ff <= rem_ff;
      hh1_ff  <= hh1_in;

      doe2_ff  <= doe_full[17:0];
      era2_ff  <= era1_ff;
      hh2_ff   <= hh1_ff;
      remh2_ff <= remh_full[11:0];

      t3_ff    <= t3_in;
      doe3_ff  <= doe2_ff;
      era3_ff  <= era2_ff;
      hh3_ff   <= hh2_ff;
      mm3_ff   <= mm3_in;
      remh3_ff <= remh2_ff;

      yoe4_ff <= yoe4_in;
      doe4_ff <= doe3_ff;
      era4_ff <= era3_ff;
      hh4_ff  <= hh3_ff;
      mm4_ff  <= mm3_ff;
      ss4_ff  <= ss_full[5:0];

      doy5_ff   <= doy_full[8:0];
      ybase5_ff <= ybase5_in;
      hh5_ff    <= hh4_ff;
      mm5_ff    <= mm4_ff;
      ss5_ff    <= ss4_ff;

      mp6_ff    <= mp6_in;
      doy6_ff   <= doy5_ff;
      ybase6_ff <= ybase5_ff;
      hh6_ff    <= hh5_ff;
      mm6_ff    <= mm5_ff;
      ss6_ff    <= ss5_ff;

      day7_ff   <= day_full[4:0];
      month7_ff <= month7_in;
      year7_ff  <= ybase6_ff + 14'(early);
      hh7_ff    <= hh6_ff;
      mm7_ff    <= mm6_ff;
      ss7_ff    <= ss6_ff;

      yh8_ff    <= yh8_in;
      year8_ff  <= year7_ff;
      month8_ff <= month7_ff;
      day8_ff   <= day7_ff;
      hh8_ff    <= hh7_ff;
      mm8_ff    <= mm7_ff;
      ss8_ff    <= ss7_ff;

      pair9_ff[0] <= yh8_ff;
      pair9_ff[1] <= yl_full[6:0];
      pair9_ff[2] <= 7'(month8_ff);
      pair9_ff[3] <= 7'(day8_ff);
      pair9_ff[4] <= 7'(hh8_ff);
      pair9_ff[5] <= 7'(mm8_ff);
      pair9_ff[6] <= 7'(ss8_ff);

      for (int i = 0; i < 7; i++) begin
         pair10_ff[i] <= pair9_ff[i];
         tens10_ff[i] <= tens_prod[i][D10_SHIFT +: 4];
      end

      line11_ff <= line11_in;
   end

endmodule

/* src/ets_emit.sv */
module ets_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          line_empty,
   input  ets_pkg::line_type             line_data,
   output logic                          line_pop,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [ets_pkg::CHAR_W-1:0]    rsp_text_char,
   output logic                          rsp_last_char
);
   import ets_pkg::*;

   logic       valid_ff, valid_in;
   logic [3:0] idx_ff, idx_in;
   line_type   cur_ff;
   logic       finish, load;
   logic [3:0] pos;

   assign finish = valid_ff && rsp_pop && (idx_ff == POS_Z);
   // next line loads in the same cycle the closing Z is taken, when a line is waiting
   assign load     = (!valid_ff || finish) && !line_empty;
   assign line_pop = load;

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (finish) begin
         valid_in = 1'b0;
      end else if (valid_ff && rsp_pop) begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_comb begin
      pos = (idx_ff < POS_T) ? idx_ff : idx_ff - 4'd1;
      priority if (idx_ff == POS_T) begin
         rsp_text_char = CHAR_T;
      end else if (idx_ff == POS_Z) begin
         rsp_text_char = CHAR_Z;
      end else begin
         rsp_text_char = CHAR_ZERO + CHAR_W'(cur_ff[pos]);
      end
   end

   assign rsp_last_char = (idx_ff == POS_Z);
   assign rsp_empty     = !valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= line_data;
      end
   end

endmodule

/* bench/epoch_seconds_to_iso_text_top_tb.sv */
`timescale 1ns / 1ps

module epoch_seconds_to_iso_text_top_tb;

   localparam longint EARLIEST    = -64'sd17987443200;   // 1400-01-01T00:00:00Z
   localparam longint LATEST      = 64'sd253402300799;   // 9999-12-31T23:59:59Z
   localparam longint DAY_SECONDS = 64'sd86400;
   localparam int     LAST_DAY    = 3141084;             // day index of 9999-12-31
   localparam logic [6:0] CODE_ZERO = 7'h30;
   localparam logic [6:0] CODE_T    = 7'h54;
   localparam logic [6:0] CODE_Z    = 7'h5A;
   localparam int RANDOM_ITEMS = 100;
   localparam int HOLD_AFTER   = 160;    // characters seen before the long hold-off
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 60;
   localparam int STALL_LIMIT  = 5000;
   localparam int PRINT_LIMIT  = 50;

   typedef enum int {PACE_STREAM, PACE_BURSTY, PACE_BRISK} pace_type;

   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } iso_char_type;

   logic                       clock;
   logic                       reset;
   logic                       req_push;
   logic signed [38:0]         req_epoch_seconds;
   logic                       req_full;
   logic                       rsp_empty;
   logic                       rsp_pop;
   logic [ets_pkg::CHAR_W-1:0] rsp_text_char;
   logic                       rsp_last_char;

   logic signed [38:0] pending_secs[$];
   iso_char_type       expected_chars[$];
   logic               push_taken;
   logic               char_taken;
   int                 chars_seen;
   int                 line_pos;
   int                 mismatches;

   epoch_seconds_to_iso_text_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_epoch_seconds (req_epoch_seconds),
      .req_full          (req_full),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_text_char     (rsp_text_char),
      .rsp_last_char     (rsp_last_char)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT)
         $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic int draw_wait(input pace_type pace);
      case (pace)
         PACE_STREAM: return 0;
         PACE_BURSTY: return $urandom_range(0, 16);
         default:     return $urandom_range(0, 2);
      endcase
   endfunction

   function automatic pace_type next_pace(input pace_type pace);
      if ($urandom_range(0, 23) == 0)
         return pace_type'($urandom_range(0, 2));
      return pace;
   endfunction

   // clamp, floor-split into day and second of day, then civil date in
   // 400-year eras counted from 0000-03-01
   task automatic predict_iso_text(input logic signed [38:0] secs);
      longint s, days, tod, z, era, doe, yoe, year, doy, mp, month, mday;
      longint pair_val[7];
      s = secs;
      if (s < EARLIEST) s = EARLIEST;
      if (s > LATEST) s = LATEST;
      days = s / DAY_SECONDS;
      tod  = s % DAY_SECONDS;
      if (tod < 0) begin
         tod  += DAY_SECONDS;
         days -= 1;
      end
      z     = days + 719468;
      era   = (z >= 0 ? z : z - 146096) / 146097;
      doe   = z - era * 146097;
      yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      year  = yoe + era * 400;
      doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp    = (5 * doy + 2) / 153;
      mday  = doy - (153 * mp + 2) / 5 + 1;
      month = mp < 10 ? mp + 3 : mp - 9;
      if (month <= 2) year += 1;
      pair_val = '{year / 100, year % 100, month, mday, tod / 3600, (tod / 60) % 60, tod % 60};
      for (int p = 0; p < 7; p++) begin
         if (p == 4) expected_chars.push_back(iso_char_type'{CODE_T, 1'b0});
         expected_chars.push_back(iso_char_type'{7'(CODE_ZERO + pair_val[p] / 10), 1'b0});
         expected_chars.push_back(iso_char_type'{7'(CODE_ZERO + pair_val[p] % 10), 1'b0});
      end
      expected_chars.push_back(iso_char_type'{CODE_Z, 1'b1});
   endtask

   // sender: holds an item until taken, then waits its drawn gap
   pace_type send_pace = PACE_STREAM;
   int       send_gap  = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && !push_taken) begin
         // item still on offer
      end else if (send_gap > 0) begin
         req_push <= 1'b0;
         send_gap--;
      end else if (pending_secs.size() != 0) begin
         req_epoch_seconds <= pending_secs.pop_front();
         req_push <= 1'b1;
         send_pace = next_pace(send_pace);
         send_gap  = draw_wait(send_pace);
      end else begin
         req_push <= 1'b0;
      end
   end

   // receiver: random stalls between characters, plus one long hold-off to back up the block
   pace_type take_pace = PACE_BURSTY;
   int       take_gap  = 0;
   int       hold_left = 0;
   bit       hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rsp_pop && !char_taken) begin
         // waiting for a character to show
      end else if (!hold_done && chars_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_pop <= 1'b0;
         hold_left--;
      end else if (take_gap > 0) begin
         rsp_pop <= 1'b0;
         take_gap--;
      end else begin
         rsp_pop <= 1'b1;
         take_pace = next_pace(take_pace);
         take_gap  = draw_wait(take_pace);
      end
   end

   always @(posedge clock) begin
      iso_char_type want;
      if (reset) begin
         push_taken <= 1'b0;
         char_taken <= 1'b0;
      end else begin
         push_taken <= req_push && !req_full;
         char_taken <= rsp_pop && !rsp_empty;
         if (req_push && !req_full)
            predict_iso_text(req_epoch_seconds);
         if (rsp_pop && !rsp_empty) begin
            chars_seen <= chars_seen + 1;
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("character %h with no item pending", rsp_text_char));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_text_char !== want.code)
                  report_mismatch($sformatf("position %0d text_char %h, want %h",
                                            line_pos, rsp_text_char, want.code));
               if (rsp_last_char !== want.last)
                  report_mismatch($sformatf("position %0d last_char %b, want %b",
                                            line_pos, rsp_last_char, want.last));
               line_pos <= want.last ? 0 : line_pos + 1;
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("epoch_seconds_to_iso_text_top_tb NOT OK");
      $finish;
   end

   initial begin
      longint boundary_secs[] = '{
         EARLIEST, EARLIEST - 64'sd1, -64'sd274877906944,
         LATEST, LATEST + 64'sd1, 64'sd274877906943,
         64'sd0, -64'sd1, 64'sd86399, 64'sd86400, -64'sd86400, -64'sd86401,
         64'sd951782400,      // 2000-02-29, leap day of a 400-year
         64'sd951868800,      // 2000-03-01
         -64'sd2203891201,    // 1900-02-28 last second, century without leap day
         64'sd4107542399,     // 2100-02-28 last second
         64'sd946684799,      // 1999-12-31 last second
         64'sd2147483648,
         -64'sd17982345601,   // 1400-02-28 last second
         64'sd253402214400    // 9999-12-31 midnight
      };
      bit [63:0]          rnd;
      logic signed [38:0] item;
      longint             span;
      int                 pick;

      clock             = 1'b0;
      reset             = 1'b1;
      req_push          = 1'b0;
      req_epoch_seconds = '0;
      rsp_pop           = 1'b0;
      chars_seen        = 0;
      line_pos          = 0;
      mismatches        = 0;
      span              = LATEST - EARLIEST + 64'sd1;

      foreach (boundary_secs[i])
         pending_secs.push_back(39'(boundary_secs[i]));
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         rnd  = {$urandom(), $urandom()};
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            item = rnd[38:0];                      // anywhere, mostly saturating
         end else if (pick <= 4) begin
            // a day edge somewhere in range
            case ($urandom_range(0, 2))
               0:       item = 39'(EARLIEST + longint'($urandom_range(0, LAST_DAY)) * DAY_SECONDS);
               1:       item = 39'(EARLIEST + longint'($urandom_range(0, LAST_DAY)) * DAY_SECONDS
                               + DAY_SECONDS - 64'sd1);
               default: item = 39'(EARLIEST + longint'($urandom_range(0, LAST_DAY)) * DAY_SECONDS
                               + longint'($urandom_range(0, 86399)));
            endcase
         end else begin
            item = 39'(EARLIEST + longint'(rnd % span));
         end
         pending_secs.push_back(item);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_secs.size() != 0 || req_push) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("epoch_seconds_to_iso_text_top_tb OK");
      else
         $display("epoch_seconds_to_iso_text_top_tb NOT OK");
      $finish;
   end

endmodule
